// ===== hdl/keyed_running_mean_variance_defines.svh =====
// Assertion macros for the keyed running mean and variance block
`ifndef KEYED_RUNNING_MEAN_VARIANCE_DEFINES_SVH
`define KEYED_RUNNING_MEAN_VARIANCE_DEFINES_SVH

// Assert an implication on every clock edge outside reset
`define KRMV_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Assert an implication whose consequent is checked in the cycle after the antecedent
`define KRMV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/krmv_pkg.sv =====
// Package with widths, status codes and slot layout for the mean and variance block
`default_nettype none
package krmv_pkg;
    localparam int TABLE_ENTRIES = 256;
    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int USED_W = SLOT_W + 1;
    localparam int FRAC_BITS = 16;

    localparam logic [2:0] ST_UPDATED = 3'd0;
    localparam logic [2:0] ST_NEW     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] count;
        logic [31:0] mean;
        logic [63:0] dev_sum;
        logic [63:0] variance;
    } entry_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } div_req_t;
endpackage
`default_nettype wire

// ===== hdl/krmv_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module krmv_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire krmv_pkg::div_req_t req,
    output logic                   done,
    output logic [63:0]            quotient
);
    import krmv_pkg::*;

    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [32:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                den_reg  <= req.divisor;
            end else if (busy_reg) begin
                if (!trial[33]) begin
                    rem_reg <= trial[32:0];
                end else begin
                    rem_reg <= {rem_reg[31:0], quo_reg[63]};
                end
                quo_reg <= {quo_reg[62:0], !trial[33]};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== hdl/keyed_running_mean_variance.sv =====
// Top level of the keyed running mean and variance engine
// Items are handled one at a time; the key search reads the slots in turn and each of the
// two 64-step divisions runs to completion; the next item is taken while a result waits.
// Reset clears the used-entry count; the entry memory keeps its contents.
`default_nettype none
module keyed_running_mean_variance (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [71:0]   s_tdata,  // group_key, sample, read_slot
    input  wire logic          s_tuser,  // kind
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [183:0]       m_tdata   // status, slot_index, key_out, count_out,
                                         // mean_out, variance_out, entries_in_use, pad
);
    import krmv_pkg::*;

    typedef enum logic [3:0] {
        IDLE, RD_WAIT, SEARCH, SRCH_CHK, LOAD, DIV1, MULT, PROD, SUMUP, DIV2, WRITE, EMIT
    } state_t;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic rd_en;
    logic wr_en;
    entry_t wr_data;

    state_t state_reg;
    logic [31:0] key_reg;
    logic signed [31:0] smp_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] idx_reg;
    entry_t      ent_reg;
    logic signed [33:0] delta_reg;
    logic signed [33:0] mnew_reg;
    logic [63:0] prod_reg;
    logic [2:0]  st_reg;
    logic [183:0] out_reg;
    logic        ovalid_reg;
    div_req_t    dreq;
    logic        ddone;
    logic [63:0] dquo;
    logic [31:0] n_inc;
    logic [64:0] sum_w;
    logic [32:0] a_abs, b_abs;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[slot_reg] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    krmv_divider u_div (.aclk, .aresetn, .req(dreq), .done(ddone), .quotient(dquo));

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    assign n_inc = (ent_reg.count == 32'hFFFF_FFFF) ? ent_reg.count : ent_reg.count + 32'd1;
    assign a_abs = mnew_reg[33] ? 33'(-mnew_reg) : mnew_reg[32:0];
    assign b_abs = delta_reg[33] ? 33'(-delta_reg) : delta_reg[32:0];
    assign sum_w = {1'b0, ent_reg.dev_sum} + {1'b0, prod_reg};

    always_comb begin
        rd_en = 1'b0;
        rd_addr = idx_reg[SLOT_W-1:0];
        wr_en = (state_reg == WRITE);
        wr_data = ent_reg;
        dreq.start = 1'b0;
        dreq.dividend = '0;
        dreq.divisor = '0;
        unique case (state_reg)
            IDLE: begin
                rd_en = s_tvalid && s_tready;
                rd_addr = s_tdata[64 +: SLOT_W];
            end
            SEARCH: rd_en = 1'b1;
            LOAD: begin
                dreq.start = 1'b1;
                dreq.dividend = {31'd0, b_abs};
                dreq.divisor = {1'b0, n_inc};
            end
            SUMUP: begin
                dreq.start = 1'b1;
                dreq.dividend = sum_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_w[63:0];
                dreq.divisor = {1'b0, ent_reg.count - 32'd1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= IDLE;
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ((state_reg == EMIT) && (!ovalid_reg || m_tready)) ||
                          (ovalid_reg && !m_tready);
            unique case (state_reg)
                IDLE: begin
                    if (s_tvalid && s_tready) begin
                        key_reg  <= s_tdata[31:0];
                        smp_reg  <= s_tdata[63:32];
                        slot_reg <= s_tdata[64 +: SLOT_W];
                        idx_reg  <= '0;
                        state_reg <= s_tuser ? RD_WAIT : SEARCH;
                    end
                end
                RD_WAIT: begin
                    if ({1'b0, slot_reg} < used_reg) begin
                        st_reg <= ST_READ;
                        ent_reg <= rd_data_reg;
                    end else begin
                        st_reg <= ST_EMPTY;
                        ent_reg <= '0;
                    end
                    state_reg <= EMIT;
                end
                SEARCH: begin
                    if (idx_reg >= used_reg) begin
                        if (used_reg == USED_W'(TABLE_ENTRIES)) begin
                            st_reg <= ST_FULL;
                            slot_reg <= '0;
                            ent_reg <= '{key: key_reg, count: '0, mean: '0,
                                         dev_sum: '0, variance: '0};
                            state_reg <= EMIT;
                        end else begin
                            slot_reg <= used_reg[SLOT_W-1:0];
                            used_reg <= used_reg + USED_W'(1);
                            st_reg <= ST_NEW;
                            ent_reg <= '{key: key_reg, count: '0, mean: '0,
                                         dev_sum: '0, variance: '0};
                            delta_reg <= 34'(smp_reg);
                            state_reg <= LOAD;
                        end
                    end else begin
                        state_reg <= SRCH_CHK;
                    end
                end
                SRCH_CHK: begin
                    if (rd_data_reg.key == key_reg) begin
                        slot_reg <= idx_reg[SLOT_W-1:0];
                        st_reg <= ST_UPDATED;
                        ent_reg <= rd_data_reg;
                        delta_reg <= 34'(smp_reg) - 34'($signed(rd_data_reg.mean));
                        state_reg <= LOAD;
                    end else begin
                        idx_reg <= idx_reg + USED_W'(1);
                        state_reg <= SEARCH;
                    end
                end
                LOAD: state_reg <= DIV1;
                DIV1: begin
                    if (ddone) begin
                        ent_reg.count <= n_inc;
                        mnew_reg <= delta_reg[33]
                            ? 34'($signed(ent_reg.mean)) - 34'(dquo[32:0])
                            : 34'($signed(ent_reg.mean)) + 34'(dquo[32:0]);
                        state_reg <= MULT;
                    end
                end
                MULT: begin
                    ent_reg.mean <= mnew_reg[31:0];
                    mnew_reg <= 34'(smp_reg) - mnew_reg;
                    state_reg <= PROD;
                end
                PROD: state_reg <= SUMUP;
                SUMUP: state_reg <= DIV2;
                DIV2: begin
                    if (ddone) begin
                        ent_reg.dev_sum <= sum_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_w[63:0];
                        ent_reg.variance <= (ent_reg.count >= 32'd2) ? dquo : 64'd0;
                        state_reg <= WRITE;
                    end
                end
                WRITE: state_reg <= EMIT;
                EMIT: begin
                    if (!ovalid_reg || m_tready) begin
                        out_reg <= {4'd0, used_reg, ent_reg.variance, ent_reg.mean,
                                    ent_reg.count, ent_reg.key, slot_reg, st_reg};
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == PROD) prod_reg <= 64'(b_abs) * 64'(a_abs);
    end
endmodule
`default_nettype wire

// ===== hdl/krmv_checker.sv =====
// Port checker for the keyed running mean and variance engine
`default_nettype none
`include "keyed_running_mean_variance_defines.svh"
module krmv_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [183:0] m_tdata
);
    `KRMV_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `KRMV_ASSERT_IMP(a_status, aclk, aresetn, m_tvalid, m_tdata[2:0] <= 3'd4, "bad status")
    `KRMV_ASSERT_IMP(a_used, aclk, aresetn, m_tvalid, m_tdata[179:171] <= 9'd256, "count overflow")
    `KRMV_ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken")
endmodule
bind keyed_running_mean_variance krmv_checker u_chk (.*);
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the keyed running mean and variance engine: driven, predicted and checked
`timescale 1ns / 1ps
module tb;
    import krmv_pkg::*;

    typedef struct {
        logic        kind;
        logic [31:0] key;
        logic [31:0] sample;
        logic [7:0]  slot;
        logic        pause;
    } item_t;

    typedef struct packed {
        logic [8:0]  used;
        logic [63:0] variance;
        logic [31:0] mean;
        logic [31:0] count;
        logic [31:0] key;
        logic [7:0]  slot;
        logic [2:0]  status;
    } stats_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [71:0]   s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [183:0]  m_tdata;

    keyed_running_mean_variance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    item_t       pending_items[$];
    stats_t      stats_due[$];
    logic [31:0] grp_key[TABLE_ENTRIES];
    logic [31:0] grp_count[TABLE_ENTRIES];
    logic [31:0] grp_mean[TABLE_ENTRIES];
    logic [63:0] grp_dev[TABLE_ENTRIES];
    logic [63:0] grp_var[TABLE_ENTRIES];
    int          groups_used = 0;
    int          mismatches = 0;
    int          items_in = 0;
    int          idle_cycles = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    bit          tx_burst = 0;
    bit          rx_burst = 0;
    bit          in_taken = 0;
    bit          rx_hold = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic void welford_update(int g, logic [31:0] smp);
        logic [31:0] n;
        longint      s;
        longint      m_old;
        longint      m_new;
        longint      delta;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] sum;
        n = grp_count[g];
        if (n != 32'hFFFF_FFFF) n++;
        s = longint'($signed(smp));
        m_old = longint'($signed(grp_mean[g]));
        delta = s - m_old;
        q = mag(delta) / {32'd0, n};
        m_new = delta < 0 ? m_old - longint'(q) : m_old + longint'(q);
        p = mag(s - m_new) * mag(s - m_old);
        sum = grp_dev[g] + p;
        if (sum < p) sum = '1;
        grp_count[g] = n;
        grp_mean[g] = m_new[31:0];
        grp_dev[g] = sum;
        grp_var[g] = n >= 2 ? sum / {32'd0, n - 32'd1} : 64'd0;
    endfunction

    function automatic stats_t group_stats(logic [2:0] st, int g);
        stats_t r;
        r.status = st;
        r.slot = g[7:0];
        r.key = grp_key[g];
        r.count = grp_count[g];
        r.mean = grp_mean[g];
        r.variance = grp_var[g];
        r.used = groups_used[8:0];
        return r;
    endfunction

    function automatic stats_t aggregate(logic kind, logic [31:0] key, logic [31:0] smp,
                                         logic [7:0] slot);
        stats_t r;
        r = '0;
        if (kind) begin
            if (int'(slot) < groups_used) return group_stats(ST_READ, slot);
            r.status = ST_EMPTY;
            r.slot = slot;
            r.used = groups_used[8:0];
            return r;
        end
        for (int i = 0; i < groups_used; i++) begin
            if (grp_key[i] == key) begin
                welford_update(i, smp);
                return group_stats(ST_UPDATED, i);
            end
        end
        if (groups_used < TABLE_ENTRIES) begin
            grp_key[groups_used] = key;
            grp_count[groups_used] = '0;
            grp_mean[groups_used] = '0;
            grp_dev[groups_used] = '0;
            grp_var[groups_used] = '0;
            groups_used++;
            welford_update(groups_used - 1, smp);
            return group_stats(ST_NEW, groups_used - 1);
        end
        r.status = ST_FULL;
        r.key = key;
        r.used = groups_used[8:0];
        return r;
    endfunction

    // input side: advance items at the falling edge
    always @(negedge aclk) begin
        logic  v;
        item_t it;
        v = s_tvalid;
        if (in_taken) begin
            v = 1'b0;
            in_taken = 0;
        end
        if (aresetn && !v) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_items.size() > 0 &&
                         (!pending_items[0].pause || stats_due.size() == 0)) begin
                it = pending_items.pop_front();
                s_tdata <= {it.slot, it.sample, it.key};
                s_tuser <= it.kind;
                v = 1'b1;
                if ($urandom_range(0, 63) == 0) tx_burst = ~tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 12);
            end
        end
        s_tvalid <= v;
    end

    // result side: hold off or accept
    always @(negedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        stats_t got;
        stats_t want;
        bit     moved;
        moved = 0;
        if (aresetn && s_tvalid && s_tready) begin
            stats_due.push_back(aggregate(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                          s_tdata[71:64]));
            in_taken = 1;
            items_in++;
            moved = 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            moved = 1;
            got = m_tdata[179:0];
            if (stats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %h", got);
            end else begin
                want = stats_due.pop_front();
                if (got.status != want.status || got.slot != want.slot ||
                    got.key != want.key || got.count != want.count ||
                    got.mean != want.mean || got.variance != want.variance ||
                    got.used != want.used) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: st %0d/%0d slot %0d/%0d key %h/%h ",
                                  "cnt %0d/%0d mean %h/%h var %h/%h used %0d/%0d"},
                                 want.status, got.status, want.slot, got.slot,
                                 want.key, got.key, want.count, got.count,
                                 want.mean, got.mean, want.variance, got.variance,
                                 want.used, got.used);
                end
            end
            if ($urandom_range(0, 63) == 0) rx_burst = ~rx_burst;
            rx_gap = rx_burst ? 0 : $urandom_range(0, 12);
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= 20000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // long stall on the result side while items keep coming
    initial begin
        wait (items_in >= 300);
        rx_hold = 1;
        repeat (3000) @(posedge aclk);
        rx_hold = 0;
    end

    task automatic push_add(logic [31:0] key, logic [31:0] smp, bit pause = 0);
        item_t it;
        it = '{kind: 1'b0, key: key, sample: smp, slot: 8'($urandom), pause: pause};
        pending_items.push_back(it);
    endtask

    task automatic push_read(logic [7:0] slot);
        item_t it;
        it = '{kind: 1'b1, key: $urandom, sample: $urandom, slot: slot, pause: 1'b0};
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] rand_sample();
        if ($urandom_range(0, 1)) return $urandom;
        return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    endfunction

    initial begin
        logic [31:0] key_pool[64];
        foreach (key_pool[i]) key_pool[i] = $urandom;
        push_read(8'd0);
        push_read(8'd255);
        push_add(32'd0, 32'h8000_0000);
        push_add(32'd0, 32'h7FFF_FFFF);
        push_add(32'd0, 32'h7FFF_FFFF);
        push_add(32'hFFFF_FFFF, 32'd0);
        push_add(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_add(32'hFFFF_FFFF, 32'h0001_0000);
        push_add(32'h5A5A_A5A5, 32'h8000_0000);
        push_add(32'h5A5A_A5A5, 32'h8000_0000);
        push_read(8'd0);
        push_read(8'd1);
        push_read(8'd2);
        push_read(8'd3);
        push_read(8'd128);
        for (int i = 0; i < 1000; i++) begin
            if ($urandom_range(0, 9) < 7)
                push_add(key_pool[$urandom_range(0, 63)], rand_sample(), i == 500);
            else
                push_read($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 70)));
        end
        for (int i = 0; i < 240; i++) push_add(32'hA000_0000 + i, rand_sample());
        for (int i = 0; i < 520; i++) begin
            case ($urandom_range(0, 3))
                0: push_add($urandom, rand_sample());
                1: push_add(key_pool[$urandom_range(0, 63)], rand_sample());
                default: push_read(8'($urandom));
            endcase
        end
        push_read(8'd255);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (pending_items.size() == 0 && !s_tvalid && stats_due.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && stats_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/krmv_pkg.sv
hdl/krmv_divider.sv
hdl/keyed_running_mean_variance.sv
hdl/krmv_checker.sv
dv/tb.sv
